[rtl/neighbor_table_evict_farthest_top_defines.svh]
// Assertion macros used by the neighbor table top module.
`ifndef NEIGHBOR_TABLE_EVICT_FARTHEST_TOP_DEFINES_SVH
`define NEIGHBOR_TABLE_EVICT_FARTHEST_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define NTE_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define NTE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define NTE_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define NTE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

[rtl/nte_pkg.sv]
package nte_pkg;

   localparam int TABLE_SIZE_DEF = 8;
   localparam int MAX_RESULTS    = 8;

   localparam int ID_W     = 32;
   localparam int DIST_W   = 16;
   localparam int MODE_W   = 2;
   localparam int DUMP_N_W = 4;
   localparam int SLOT_W   = 3;
   localparam int COUNT_W  = 4;

   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ADD   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DUMP  = 2'd2;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [DIST_W-1:0] distance;
   } entry_type;

endpackage

[rtl/nte_if.sv]
interface nte_req_if;
   logic                          valid;
   logic                          ready;
   logic [nte_pkg::MODE_W-1:0]    mode;
   logic [nte_pkg::ID_W-1:0]      neighbor_id;
   logic [nte_pkg::DIST_W-1:0]    distance;
   logic [nte_pkg::DUMP_N_W-1:0]  dump_entries;

   modport source (output valid, mode, neighbor_id, distance, dump_entries, input ready);
   modport sink   (input valid, mode, neighbor_id, distance, dump_entries, output ready);
endinterface

interface nte_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [nte_pkg::ID_W-1:0]      out_id;
   logic [nte_pkg::DIST_W-1:0]    out_distance;
   logic [nte_pkg::SLOT_W-1:0]    slot;
   logic [nte_pkg::COUNT_W-1:0]   count_now;
   logic                          entry_valid;
   logic                          last;

   modport source (output valid, out_id, out_distance, slot, count_now, entry_valid, last,
                   input ready);
   modport sink   (input valid, out_id, out_distance, slot, count_now, entry_valid, last,
                   output ready);
endinterface

[rtl/neighbor_table_evict_farthest_top.sv]
// Neighbor table, fixed size, evicting the farthest entry when full.
// req_ch (valid/ready) takes one word per command: mode 0 clears the table,
// mode 1 adds neighbor_id/distance, mode 2 dumps dump_entries slots (capped
// at TABLE_SIZE and MAX_RESULTS) from slot 0; mode 3 is dropped with no
// response. rsp_ch (valid/ready) returns one word for clear and add, and one
// word per slot for a dump (at least one word), with last set on the final
// word of a command. One command at a time. Clear, add to a non-full table
// and empty dump go straight to the emit state; add to a full table first
// scans every slot through the single store read port into one distance
// comparator and writes the new entry over the farthest one; a dump passes
// each word through one store read, a data state and the emit state.
// req_ch.ready is high whenever the sequencer is idle, even with a response
// word still held in the output register. A stalled rsp_ch holds that word
// and the sequencer waits in its emit state until the register frees up.
// Reset (synchronous) empties the table; all slots then read as zero.
`include "neighbor_table_evict_farthest_top_defines.svh"

module neighbor_table_evict_farthest_top #(
   parameter int TABLE_SIZE = nte_pkg::TABLE_SIZE_DEF,
   localparam int IDX_W = $clog2(TABLE_SIZE)
) (
   input logic        clock,
   input logic        reset,
   nte_req_if.sink    req_ch,
   nte_rsp_if.source  rsp_ch
);

   localparam int CNT_W    = $clog2(TABLE_SIZE + 1);
   localparam int DUMP_MAX = (TABLE_SIZE < nte_pkg::MAX_RESULTS) ?
                             TABLE_SIZE : nte_pkg::MAX_RESULTS;
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_SIZE);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);
   localparam logic [nte_pkg::DUMP_N_W-1:0] DUMP_MAX_N = nte_pkg::DUMP_N_W'(DUMP_MAX);

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_SCAN      = 3'd1;
   localparam logic [2:0] ST_DUMP_RD   = 3'd2;
   localparam logic [2:0] ST_DUMP_DATA = 3'd3;
   localparam logic [2:0] ST_EMIT      = 3'd4;

   logic [2:0]                    state_ff, state_in;
   logic [CNT_W-1:0]              fill_ff, fill_in;
   nte_pkg::entry_type            new_ff, new_in;
   logic [nte_pkg::DUMP_N_W-1:0]  dump_n_ff, dump_n_in;
   logic [IDX_W-1:0]              dump_idx_ff, dump_idx_in;
   logic [CNT_W-1:0]              rd_cnt_ff, rd_cnt_in;
   logic                          cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]              cmp_idx_ff, cmp_idx_in;
   logic [nte_pkg::DIST_W-1:0]    best_dist_ff, best_dist_in;
   logic [IDX_W-1:0]              best_idx_ff, best_idx_in;

   // pending response word
   nte_pkg::entry_type            pl_entry_ff, pl_entry_in;
   logic [IDX_W-1:0]              pl_slot_ff, pl_slot_in;
   logic [CNT_W-1:0]              pl_cnt_ff, pl_cnt_in;
   logic                          pl_ev_ff, pl_ev_in;
   logic                          pl_last_ff, pl_last_in;

   // output register
   logic                          out_vld_ff, out_vld_in;
   nte_pkg::entry_type            out_entry_ff, out_entry_in;
   logic [nte_pkg::SLOT_W-1:0]    out_slot_ff, out_slot_in;
   logic [nte_pkg::COUNT_W-1:0]   out_cnt_ff, out_cnt_in;
   logic                          out_ev_ff, out_ev_in;
   logic                          out_last_ff, out_last_in;

   logic                          st_clear, st_wr_en, st_rd_en;
   logic [IDX_W-1:0]              st_wr_addr, st_rd_addr;
   nte_pkg::entry_type            st_wr_entry, st_rd_entry;

   logic                          req_fire;
   logic                          out_free;
   logic                          take;
   logic [IDX_W-1:0]              sel_idx;
   logic [nte_pkg::DUMP_N_W-1:0]  dump_n;
   logic                          dump_last;

   nte_store #(.TABLE_SIZE(TABLE_SIZE)) u_store (
      .clock    (clock),
      .reset    (reset),
      .clear    (st_clear),
      .wr_en    (st_wr_en),
      .wr_addr  (st_wr_addr),
      .wr_entry (st_wr_entry),
      .rd_en    (st_rd_en),
      .rd_addr  (st_rd_addr),
      .rd_entry (st_rd_entry)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign out_free     = !out_vld_ff || rsp_ch.ready;

   assign dump_n    = (req_ch.dump_entries > DUMP_MAX_N) ? DUMP_MAX_N : req_ch.dump_entries;
   assign dump_last = (5'(dump_idx_ff) + 5'd1) == 5'(dump_n_ff);

   // running maximum; strict compare keeps the lowest index on a tie
   assign take    = (cmp_idx_ff == '0) || (best_dist_ff < st_rd_entry.distance);
   assign sel_idx = take ? cmp_idx_ff : best_idx_ff;

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      new_in       = new_ff;
      dump_n_in    = dump_n_ff;
      dump_idx_in  = dump_idx_ff;
      rd_cnt_in    = rd_cnt_ff;
      cmp_vld_in   = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      best_dist_in = best_dist_ff;
      best_idx_in  = best_idx_ff;
      pl_entry_in  = pl_entry_ff;
      pl_slot_in   = pl_slot_ff;
      pl_cnt_in    = pl_cnt_ff;
      pl_ev_in     = pl_ev_ff;
      pl_last_in   = pl_last_ff;
      out_vld_in   = out_vld_ff && !rsp_ch.ready;
      out_entry_in = out_entry_ff;
      out_slot_in  = out_slot_ff;
      out_cnt_in   = out_cnt_ff;
      out_ev_in    = out_ev_ff;
      out_last_in  = out_last_ff;
      st_clear     = 1'b0;
      st_wr_en     = 1'b0;
      st_wr_addr   = '0;
      st_wr_entry  = new_ff;
      st_rd_en     = 1'b0;
      st_rd_addr   = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               new_in.id       = req_ch.neighbor_id;
               new_in.distance = req_ch.distance;
               case (req_ch.mode)
                  nte_pkg::MODE_CLEAR: begin
                     st_clear    = 1'b1;
                     fill_in     = '0;
                     pl_entry_in = '0;
                     pl_slot_in  = '0;
                     pl_cnt_in   = '0;
                     pl_ev_in    = 1'b0;
                     pl_last_in  = 1'b1;
                     state_in    = ST_EMIT;
                  end
                  nte_pkg::MODE_ADD: begin
                     if (fill_ff < FULL_CNT) begin
                        st_wr_en             = 1'b1;
                        st_wr_addr           = fill_ff[IDX_W-1:0];
                        st_wr_entry.id       = req_ch.neighbor_id;
                        st_wr_entry.distance = req_ch.distance;
                        fill_in              = fill_ff + 1'b1;
                        pl_entry_in          = st_wr_entry;
                        pl_slot_in           = fill_ff[IDX_W-1:0];
                        pl_cnt_in            = fill_ff + 1'b1;
                        pl_ev_in             = 1'b1;
                        pl_last_in           = 1'b1;
                        state_in             = ST_EMIT;
                     end else begin
                        rd_cnt_in = '0;
                        state_in  = ST_SCAN;
                     end
                  end
                  nte_pkg::MODE_DUMP: begin
                     dump_n_in   = dump_n;
                     dump_idx_in = '0;
                     if (dump_n == '0) begin
                        pl_entry_in = '0;
                        pl_slot_in  = '0;
                        pl_cnt_in   = fill_ff;
                        pl_ev_in    = 1'b0;
                        pl_last_in  = 1'b1;
                        state_in    = ST_EMIT;
                     end else begin
                        state_in = ST_DUMP_RD;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (rd_cnt_ff < FULL_CNT) begin
               st_rd_en   = 1'b1;
               st_rd_addr = rd_cnt_ff[IDX_W-1:0];
               rd_cnt_in  = rd_cnt_ff + 1'b1;
               cmp_vld_in = 1'b1;
               cmp_idx_in = rd_cnt_ff[IDX_W-1:0];
            end
            if (cmp_vld_ff) begin
               if (take) begin
                  best_dist_in = st_rd_entry.distance;
               end
               best_idx_in = sel_idx;
               if (cmp_idx_ff == LAST_IDX) begin
                  st_wr_en    = 1'b1;
                  st_wr_addr  = sel_idx;
                  fill_in     = FULL_CNT;
                  pl_entry_in = new_ff;
                  pl_slot_in  = sel_idx;
                  pl_cnt_in   = FULL_CNT;
                  pl_ev_in    = 1'b1;
                  pl_last_in  = 1'b1;
                  state_in    = ST_EMIT;
               end
            end
         end
         ST_DUMP_RD: begin
            st_rd_en   = 1'b1;
            st_rd_addr = dump_idx_ff;
            state_in   = ST_DUMP_DATA;
         end
         ST_DUMP_DATA: begin
            pl_entry_in = st_rd_entry;
            pl_slot_in  = dump_idx_ff;
            pl_cnt_in   = fill_ff;
            pl_ev_in    = 1'b1;
            pl_last_in  = dump_last;
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               out_vld_in   = 1'b1;
               out_entry_in = pl_entry_ff;
               out_slot_in  = nte_pkg::SLOT_W'(pl_slot_ff);
               out_cnt_in   = nte_pkg::COUNT_W'(pl_cnt_ff);
               out_ev_in    = pl_ev_ff;
               out_last_in  = pl_last_ff;
               if (pl_last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  dump_idx_in = dump_idx_ff + 1'b1;
                  state_in    = ST_DUMP_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         fill_ff    <= '0;
         cmp_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         cmp_vld_ff <= cmp_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      new_ff       <= new_in;
      dump_n_ff    <= dump_n_in;
      dump_idx_ff  <= dump_idx_in;
      rd_cnt_ff    <= rd_cnt_in;
      cmp_idx_ff   <= cmp_idx_in;
      best_dist_ff <= best_dist_in;
      best_idx_ff  <= best_idx_in;
      pl_entry_ff  <= pl_entry_in;
      pl_slot_ff   <= pl_slot_in;
      pl_cnt_ff    <= pl_cnt_in;
      pl_ev_ff     <= pl_ev_in;
      pl_last_ff   <= pl_last_in;
      out_entry_ff <= out_entry_in;
      out_slot_ff  <= out_slot_in;
      out_cnt_ff   <= out_cnt_in;
      out_ev_ff    <= out_ev_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_ch.valid        = out_vld_ff;
   assign rsp_ch.out_id       = out_entry_ff.id;
   assign rsp_ch.out_distance = out_entry_ff.distance;
   assign rsp_ch.slot         = out_slot_ff;
   assign rsp_ch.count_now    = out_cnt_ff;
   assign rsp_ch.entry_valid  = out_ev_ff;
   assign rsp_ch.last         = out_last_ff;

   `NTE_ASSERT_NEXT(a_clear_empties, clock, reset, req_fire && (req_ch.mode == nte_pkg::MODE_CLEAR), fill_ff == '0, "clear did not empty the table")
   `NTE_ASSERT_IMPL(a_scan_only_full, clock, reset, state_ff == ST_SCAN, fill_ff == FULL_CNT, "eviction scan on a table that is not full")
   `NTE_ASSERT_IMPL(a_dump_data_order, clock, reset, state_ff == ST_DUMP_DATA, $past(state_ff) == ST_DUMP_RD, "dump data without a store read")
   `NTE_ASSERT_IMPL(a_no_accept_mid_scan, clock, reset, req_fire, !cmp_vld_ff, "command accepted while scan reads in flight")

endmodule

[rtl/nte_store.sv]
module nte_store #(
   parameter int TABLE_SIZE = nte_pkg::TABLE_SIZE_DEF,
   localparam int IDX_W = $clog2(TABLE_SIZE)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                clear,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_addr,
   input  nte_pkg::entry_type  wr_entry,
   input  logic                rd_en,
   input  logic [IDX_W-1:0]    rd_addr,
   output nte_pkg::entry_type  rd_entry
);

   nte_pkg::entry_type     mem_ff [TABLE_SIZE];
   logic [TABLE_SIZE-1:0]  valid_ff;
   nte_pkg::entry_type     rd_data_ff;
   logic                   rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_entry;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   // entries never written since reset or clear read as zero
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_entry = rd_vld_ff ? rd_data_ff : '0;

endmodule

[sim/neighbor_table_evict_farthest_top_test.sv]
`timescale 1ns / 100ps

module neighbor_table_evict_farthest_top_test;

   localparam int TBL_N          = nte_pkg::TABLE_SIZE_DEF;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 40;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_WORDS   = 310;

   // mode 3 is dropped by the block
   localparam logic [nte_pkg::MODE_W-1:0] MODE_RESERVED = 2'd3;

   typedef struct packed {
      logic [nte_pkg::ID_W-1:0]    id;
      logic [nte_pkg::DIST_W-1:0]  distance;
      logic [nte_pkg::SLOT_W-1:0]  slot;
      logic [nte_pkg::COUNT_W-1:0] count;
      logic                        valid;
      logic                        last;
   } table_word_type;

   class neighbor_table_scoreboard;
      logic [nte_pkg::ID_W-1:0]   ids[TBL_N];
      logic [nte_pkg::DIST_W-1:0] dists[TBL_N];
      int unsigned                fill;
      table_word_type             pending[$];
      int                         errors;
      int                         checked;
      int                         n_add, n_evict, n_dump, n_clear, n_unused;

      function new();
         wipe();
      endfunction

      function void wipe();
         foreach (ids[i]) begin
            ids[i]   = '0;
            dists[i] = '0;
         end
         fill = 0;
      endfunction

      function void push(logic [nte_pkg::ID_W-1:0] id, logic [nte_pkg::DIST_W-1:0] distance,
                         int unsigned slot, logic valid, logic last);
         table_word_type w;
         w.id       = id;
         w.distance = distance;
         w.slot     = slot[nte_pkg::SLOT_W-1:0];
         w.count    = fill[nte_pkg::COUNT_W-1:0];
         w.valid    = valid;
         w.last     = last;
         pending.push_back(w);
      endfunction

      function void note_request(logic [nte_pkg::MODE_W-1:0] mode,
                                 logic [nte_pkg::ID_W-1:0] nid,
                                 logic [nte_pkg::DIST_W-1:0] distance,
                                 logic [nte_pkg::DUMP_N_W-1:0] n);
         int unsigned target;
         int unsigned cnt;
         case (mode)
            nte_pkg::MODE_CLEAR: begin
               n_clear++;
               wipe();
               push('0, '0, 0, 1'b0, 1'b1);
            end
            nte_pkg::MODE_ADD: begin
               n_add++;
               if (fill < TBL_N) begin
                  target = fill;
                  fill++;
               end else begin
                  // farthest wins, lowest index on a tie
                  n_evict++;
                  target = 0;
                  for (int i = 1; i < TBL_N; i++)
                     if (dists[target] < dists[i]) target = i;
               end
               ids[target]   = nid;
               dists[target] = distance;
               push(nid, distance, target, 1'b1, 1'b1);
            end
            nte_pkg::MODE_DUMP: begin
               n_dump++;
               cnt = 32'(n);
               if (cnt > TBL_N) cnt = TBL_N;
               if (cnt > nte_pkg::MAX_RESULTS) cnt = nte_pkg::MAX_RESULTS;
               if (cnt == 0)
                  push('0, '0, 0, 1'b0, 1'b1);
               for (int k = 0; k < cnt; k++)
                  push(ids[k], dists[k], k, 1'b1, k + 1 == cnt);
            end
            default: n_unused++;
         endcase
      endfunction

      function void check_response(table_word_type got);
         table_word_type want;
         checked++;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t: unexpected word id=%h dist=%h slot=%0d count=%0d valid=%b last=%b",
                     $time, got.id, got.distance, got.slot, got.count, got.valid, got.last);
            return;
         end
         want = pending.pop_front();
         if (got.id !== want.id) begin
            errors++;
            $display("%0t: out_id expected %h actual %h", $time, want.id, got.id);
         end
         if (got.distance !== want.distance) begin
            errors++;
            $display("%0t: out_distance expected %h actual %h", $time, want.distance,
                     got.distance);
         end
         if (got.slot !== want.slot) begin
            errors++;
            $display("%0t: slot expected %0d actual %0d", $time, want.slot, got.slot);
         end
         if (got.count !== want.count) begin
            errors++;
            $display("%0t: count_now expected %0d actual %0d", $time, want.count, got.count);
         end
         if (got.valid !== want.valid) begin
            errors++;
            $display("%0t: entry_valid expected %b actual %b", $time, want.valid, got.valid);
         end
         if (got.last !== want.last) begin
            errors++;
            $display("%0t: last expected %b actual %b", $time, want.last, got.last);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   nte_req_if req_ch ();
   nte_rsp_if rsp_ch ();

   neighbor_table_evict_farthest_top i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   neighbor_table_scoreboard table_model = new();

   bit steady;          // no sender gaps while set
   bit hold_request;
   int held_cycles;
   int idle_cycles;

   always #5 clock = ~clock;

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // called just after a falling edge; returns just after a falling edge, once the word has been accepted
   task automatic send_word(logic [nte_pkg::MODE_W-1:0] mode, logic [nte_pkg::ID_W-1:0] nid,
                            logic [nte_pkg::DIST_W-1:0] distance,
                            logic [nte_pkg::DUMP_N_W-1:0] n);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_ch.valid = 1'b0;
         repeat (g) @(negedge clock);
      end
      req_ch.valid        = 1'b1;
      req_ch.mode         = mode;
      req_ch.neighbor_id  = nid;
      req_ch.distance     = distance;
      req_ch.dump_entries = n;
      do @(posedge clock); while (!req_ch.ready);
      table_model.note_request(mode, nid, distance, n);
      @(negedge clock);
   endtask

   task automatic send_random();
      int r;
      logic [nte_pkg::DIST_W-1:0] distance;
      logic [nte_pkg::DUMP_N_W-1:0] n;
      r        = $urandom_range(0, 99);
      distance = ($urandom_range(0, 99) < 40) ? nte_pkg::DIST_W'($urandom_range(0, 3))
                                               : nte_pkg::DIST_W'($urandom);
      n        = ($urandom_range(0, 9) < 8) ? nte_pkg::DUMP_N_W'($urandom_range(1, 8))
                                            : nte_pkg::DUMP_N_W'($urandom_range(0, 15));
      if (r < 58)
         send_word(nte_pkg::MODE_ADD, $urandom, distance, nte_pkg::DUMP_N_W'($urandom));
      else if (r < 88)
         send_word(nte_pkg::MODE_DUMP, $urandom, nte_pkg::DIST_W'($urandom), n);
      else if (r < 96)
         send_word(nte_pkg::MODE_CLEAR, $urandom, nte_pkg::DIST_W'($urandom),
                   nte_pkg::DUMP_N_W'($urandom));
      else
         send_word(MODE_RESERVED, $urandom, nte_pkg::DIST_W'($urandom),
                   nte_pkg::DUMP_N_W'($urandom));
   endtask

   // receiver
   initial begin
      int g;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ch.ready = 1'b0;
            repeat (HOLD_CYCLES) begin
               @(negedge clock);
               held_cycles++;
            end
         end else begin
            rsp_ch.ready = 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge clock);
            g = gap_len();
            if (g > 0) begin
               rsp_ch.ready = 1'b0;
               repeat (g) @(negedge clock);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         table_model.check_response({rsp_ch.out_id, rsp_ch.out_distance, rsp_ch.slot,
                                     rsp_ch.count_now, rsp_ch.entry_valid, rsp_ch.last});
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      req_ch.valid        = 1'b0;
      req_ch.mode         = nte_pkg::MODE_CLEAR;
      req_ch.neighbor_id  = '0;
      req_ch.distance     = '0;
      req_ch.dump_entries = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // fresh table reads as zeros, length clamping, empty dump
      send_word(nte_pkg::MODE_DUMP, '0, '0, 4'd8);
      send_word(nte_pkg::MODE_DUMP, '0, '0, 4'd0);
      send_word(nte_pkg::MODE_DUMP, '1, '1, 4'd15);
      // fill with field extremes and ties at the top distance
      send_word(nte_pkg::MODE_ADD, 32'h0000_0000, 16'h0000, 4'd0);
      send_word(nte_pkg::MODE_ADD, 32'hFFFF_FFFF, 16'hFFFF, 4'd15);
      send_word(nte_pkg::MODE_ADD, 32'hA5A5_A5A5, 16'h1234, 4'd0);
      send_word(nte_pkg::MODE_ADD, 32'h5A5A_5A5A, 16'hFFFF, 4'd0);
      send_word(nte_pkg::MODE_ADD, 32'h0000_0001, 16'h8000, 4'd0);
      send_word(nte_pkg::MODE_DUMP, '0, '0, 4'd3);
      send_word(nte_pkg::MODE_ADD, 32'h8000_0000, 16'h7FFF, 4'd0);
      send_word(nte_pkg::MODE_ADD, 32'hDEAD_BEEF, 16'h0001, 4'd0);
      send_word(nte_pkg::MODE_ADD, 32'h1234_5678, 16'hFFFF, 4'd0);
      // full: evict when the new distance ties the farthest, and when it ties the nearest
      send_word(nte_pkg::MODE_ADD, 32'hCAFE_F00D, 16'hFFFF, 4'd0);
      send_word(nte_pkg::MODE_ADD, 32'h0F0F_0F0F, 16'h0000, 4'd0);
      send_word(nte_pkg::MODE_DUMP, '0, '0, 4'd9);
      send_word(MODE_RESERVED, '1, '1, 4'd8);
      send_word(nte_pkg::MODE_DUMP, '0, '0, 4'd8);
      send_word(nte_pkg::MODE_CLEAR, '1, '1, '1);
      send_word(nte_pkg::MODE_DUMP, '0, '0, 4'd8);
      send_word(nte_pkg::MODE_DUMP, '0, '0, 4'd0);
      send_word(nte_pkg::MODE_ADD, 32'h7777_0000, 16'h00FF, 4'd0);
      send_word(nte_pkg::MODE_DUMP, '0, '0, 4'd2);

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i % 30 == 0) steady = ($urandom_range(0, 3) == 0);
         if (i == RANDOM_WORDS / 2) begin
            steady       = 1'b1;
            hold_request = 1'b1;
         end
         send_random();
      end
      req_ch.valid = 1'b0;

      while (table_model.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d commands: %0d adds (%0d into a full table), %0d dumps, %0d clears, %0d unused",
               table_model.n_add + table_model.n_dump + table_model.n_clear
               + table_model.n_unused, table_model.n_add, table_model.n_evict,
               table_model.n_dump, table_model.n_clear, table_model.n_unused);
      $display("Checked %0d response words; receiver held off for %0d cycles once",
               table_model.checked, held_cycles);
      if (table_model.errors == 0 && table_model.pending.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
